@@ src/gray_to_bilevel_packer_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the gray to bilevel packer
// Implication helpers, same-cycle and next-cycle, reset disables the check.
// ----------------------------------------------------------------------------
`ifndef GRAY_TO_BILEVEL_PACKER_MACROS_SVH
`define GRAY_TO_BILEVEL_PACKER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define GBP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define GBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/gbp_pkg.sv @@
// ----------------------------------------------------------------------------
// gbp_pkg
// Types and constants shared by the gray to bilevel packer.
// ----------------------------------------------------------------------------
package gbp_pkg;

   localparam int unsigned BYTE_BITS = 8;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_ABOVE_MAX = 2'd1;
   localparam logic [1:0] ST_EARLY_END = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_MAX_VALUE    = 2'd2;

   typedef struct packed {
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [7:0]  max_value;
   } cfg_type;

   // item held in the input register
   typedef struct packed {
      logic       valid;
      logic [7:0] pixel;
      logic       end_of_input;
   } stage_type;

endpackage

@@ src/gbp_interfaces.sv @@
// ----------------------------------------------------------------------------
// gbp interfaces
// Valid/ready channels for pixels, packed bytes and register writes.
// ----------------------------------------------------------------------------
interface gbp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel;
   logic       end_of_input;

   modport source (output valid, output pixel, output end_of_input, input ready);
   modport sink   (input valid, input pixel, input end_of_input, output ready);
endinterface

interface gbp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] packed_byte;
   logic [1:0] status;
   logic       last;

   modport source (output valid, output packed_byte, output status, output last,
                   input ready);
   modport sink   (input valid, input packed_byte, input status, input last,
                   output ready);
endinterface

interface gbp_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/gbp_csr_regs.sv @@
// ----------------------------------------------------------------------------
// gbp_csr_regs
// Image width, height and maximum gray value registers.
// ----------------------------------------------------------------------------
module gbp_csr_regs (
   input  logic            clock,
   input  logic            reset,
   gbp_csr_if.sink         csr_ch,
   output gbp_pkg::cfg_type cfg
);

   gbp_pkg::cfg_type cfg_ff;
   gbp_pkg::cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            gbp_pkg::CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_ch.data;
            gbp_pkg::CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_ch.data;
            gbp_pkg::CSR_MAX_VALUE:    cfg_in.max_value    = csr_ch.data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= 16'd1;
         cfg_ff.image_height <= 16'd1;
         cfg_ff.max_value    <= 8'd255;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/gbp_in_stage.sv @@
// ----------------------------------------------------------------------------
// gbp_in_stage
// Input register: holds one pixel item until the packer takes it.
// ----------------------------------------------------------------------------
module gbp_in_stage (
   input  logic              clock,
   input  logic              reset,
   gbp_req_if.sink           req_ch,
   input  logic              advance,
   output gbp_pkg::stage_type stage
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] pixel_ff;
   logic       eoi_ff;
   logic       accept;

   assign req_ch.ready = !valid_ff || advance;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pixel_ff <= req_ch.pixel;
         eoi_ff   <= req_ch.end_of_input;
      end
   end

   assign stage.valid        = valid_ff;
   assign stage.pixel        = pixel_ff;
   assign stage.end_of_input = eoi_ff;

endmodule

@@ src/gbp_pack_core.sv @@
// ----------------------------------------------------------------------------
// gbp_pack_core
// Threshold, bit packing, row and image counting, and the result register.
// ----------------------------------------------------------------------------
module gbp_pack_core (
   input  logic              clock,
   input  logic              reset,
   input  gbp_pkg::stage_type stage,
   input  gbp_pkg::cfg_type   cfg,
   output logic              advance,
   gbp_rsp_if.source         rsp_ch
);

   logic [7:0]  acc_ff,  acc_in;
   logic [2:0]  fill_ff, fill_in;
   logic [15:0] col_ff,  col_in;
   logic [15:0] row_ff,  row_in;
   logic        done_ff, done_in;

   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff,  out_byte_in;
   logic [1:0]  out_status_ff, out_status_in;
   logic        out_last_ff,  out_last_in;

   logic        proc;
   logic        emit;
   logic [8:0]  max_plus;
   logic [7:0]  threshold;
   logic        dark;
   logic [7:0]  acc_set;
   logic [15:0] col_inc;
   logic [15:0] row_inc;
   logic        row_end;
   logic        image_end;
   logic [3:0]  pad_shift;
   logic [7:0]  pad;

   assign advance = !out_valid_ff || rsp_ch.ready;
   assign proc    = stage.valid && advance;

   assign max_plus  = {1'b0, cfg.max_value} + 9'd1;
   assign threshold = max_plus[8:1];
   assign dark      = stage.pixel <= threshold;
   assign acc_set   = acc_ff | ({7'd0, dark} << (3'd7 - fill_ff));
   assign col_inc   = col_ff + 16'd1;
   assign row_inc   = row_ff + 16'd1;
   assign row_end   = col_inc == cfg.image_width;
   assign image_end = row_end && (row_inc == cfg.image_height);
   // unused low bits of a partial byte are padded with ones
   assign pad_shift = {1'b0, fill_ff} + 4'd1;
   assign pad       = 8'hFF >> pad_shift;

   always_comb begin
      acc_in        = acc_ff;
      fill_in       = fill_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      done_in       = done_ff;
      emit          = 1'b0;
      out_byte_in   = out_byte_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;

      if (proc && !done_ff) begin
         if (stage.end_of_input) begin
            done_in       = 1'b1;
            emit          = 1'b1;
            out_byte_in   = 8'd0;
            out_status_in = gbp_pkg::ST_EARLY_END;
            out_last_in   = 1'b1;
         end else if (stage.pixel > cfg.max_value) begin
            done_in       = 1'b1;
            emit          = 1'b1;
            out_byte_in   = 8'd0;
            out_status_in = gbp_pkg::ST_ABOVE_MAX;
            out_last_in   = 1'b1;
         end else begin
            if (row_end) begin
               col_in  = 16'd0;
               row_in  = row_inc;
               done_in = image_end;
            end else begin
               col_in = col_inc;
            end
            if (fill_ff == 3'd7 || row_end) begin
               emit          = 1'b1;
               out_byte_in   = acc_set | pad;
               out_status_in = gbp_pkg::ST_OK;
               out_last_in   = image_end;
               acc_in        = 8'd0;
               fill_in       = 3'd0;
            end else begin
               acc_in  = acc_set;
               fill_in = fill_ff + 3'd1;
            end
         end
      end

      out_valid_in = out_valid_ff;
      if (proc && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= 8'd0;
         fill_ff      <= 3'd0;
         col_ff       <= 16'd0;
         row_ff       <= 16'd0;
         done_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         fill_ff      <= fill_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         done_ff      <= done_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff   <= out_byte_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.packed_byte = out_byte_ff;
   assign rsp_ch.status      = out_status_ff;
   assign rsp_ch.last        = out_last_ff;

endmodule

@@ src/gray_to_bilevel_packer.sv @@
// ----------------------------------------------------------------------------
// gray_to_bilevel_packer
// Thresholds gray pixels and packs them MSB first into bilevel bytes.
// Path: an accepted pixel passes the input register, then the result register,
// before a byte that it completes appears on rsp_ch.
// Throughput: one pixel per cycle while rsp_ch is ready; a byte left waiting
// holds the input register, and req_ch stalls once that is full as well.
// Reset: synchronous; registers return to width 1, height 1, max 255 and
// all counters clear. After the last byte or an error, items are dropped.
// ----------------------------------------------------------------------------
module gray_to_bilevel_packer (
   input logic     clock,
   input logic     reset,
   gbp_req_if.sink   req_ch,
   gbp_rsp_if.source rsp_ch,
   gbp_csr_if.sink   csr_ch
);

   gbp_pkg::cfg_type   cfg;
   gbp_pkg::stage_type stage;
   logic               advance;

   gbp_csr_regs u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   gbp_in_stage u_in (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .advance (advance),
      .stage   (stage)
   );

   gbp_pack_core u_core (
      .clock   (clock),
      .reset   (reset),
      .stage   (stage),
      .cfg     (cfg),
      .advance (advance),
      .rsp_ch  (rsp_ch)
   );

endmodule

@@ src/gbp_checker.sv @@
// ----------------------------------------------------------------------------
// gbp_checker
// Port-level checks on the packer's result channel.
// ----------------------------------------------------------------------------
`include "gray_to_bilevel_packer_macros.svh"

module gbp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_byte,
   input logic [1:0] rsp_status,
   input logic       rsp_last
);

   // error items carry a zero byte and close the image
   `GBP_ASSERT_SAME(a_error_is_last, clock, reset, rsp_valid && rsp_status != gbp_pkg::ST_OK, rsp_last && rsp_byte == 8'd0, "error item not last or byte not zero")

   // nothing follows the final item
   `GBP_ASSERT_NEXT(a_quiet_after_last, clock, reset, rsp_valid && rsp_ready && rsp_last, !rsp_valid, "item after last")

   `GBP_ASSERT_SAME(a_idle_after_reset, clock, reset, $past(reset), !rsp_valid, "result valid right after reset")

   `GBP_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_byte) && $stable(rsp_status) && $stable(rsp_last), "stalled item changed")

endmodule

bind gray_to_bilevel_packer gbp_checker u_gbp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_byte   (rsp_ch.packed_byte),
   .rsp_status (rsp_ch.status),
   .rsp_last   (rsp_ch.last)
);

@@ verif/tb_gray_to_bilevel_packer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gray_to_bilevel_packer
// Streams gray pixels into the packer and checks every packed byte against a
// local predictor of the threshold and packing rules. Register writes happen
// only with the pipe empty. The run is one image, since only reset clears the
// closed state: directed patterns first, then random rows under three idling
// regimes, then a random way of closing the image and items that must be
// dropped.
// ----------------------------------------------------------------------------
module tb_gray_to_bilevel_packer;

   typedef struct packed {
      logic [7:0] packed_byte;
      logic [1:0] status;
      logic       last;
   } bilevel_byte_type;

   typedef enum int {CLOSE_COMPLETE, CLOSE_ABOVE_MAX, CLOSE_EARLY_END} image_close_type;

   logic clock;
   logic reset;

   gbp_req_if req_ch ();
   gbp_rsp_if rsp_ch ();
   gbp_csr_if csr_ch ();

   gray_to_bilevel_packer u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predictor state, mirrors the block after reset
   gbp_pkg::cfg_type shadow_cfg = '{16'd1, 16'd1, 8'd255};
   logic [7:0]  pack_acc   = '0;
   logic [2:0]  pack_fill  = '0;
   logic [15:0] col_cnt    = '0;
   logic [15:0] row_cnt    = '0;
   logic        image_done = 1'b0;

   bilevel_byte_type pending_bytes[$];

   int send_gap_pct = 0;
   int stall_pct    = 0;
   int pixels_sent  = 0;
   int dropped_sent = 0;
   int bytes_checked = 0;
   int fail_count   = 0;
   image_close_type close_kind = CLOSE_COMPLETE;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("gray_to_bilevel_packer verification failed");
      $finish;
   end

   function automatic void threshold_and_pack(input logic [7:0] px, input logic eoi);
      int         thr;
      int         fill;
      logic [7:0] out_byte;
      logic       row_end;
      logic       last_row;
      last_row = 1'b0;
      if (image_done) return;
      if (eoi) begin
         image_done = 1'b1;
         pending_bytes.push_back('{8'h00, gbp_pkg::ST_EARLY_END, 1'b1});
         return;
      end
      if (px > shadow_cfg.max_value) begin
         image_done = 1'b1;
         pending_bytes.push_back('{8'h00, gbp_pkg::ST_ABOVE_MAX, 1'b1});
         return;
      end
      thr  = (int'(shadow_cfg.max_value) + 1) / 2;
      fill = int'(pack_fill) + 1;
      if (int'(px) <= thr) pack_acc[8 - fill] = 1'b1;
      col_cnt = col_cnt + 16'd1;
      row_end = (col_cnt == shadow_cfg.image_width);
      if (row_end) begin
         col_cnt = '0;
         row_cnt = row_cnt + 16'd1;
         if (row_cnt == shadow_cfg.image_height) begin
            last_row   = 1'b1;
            image_done = 1'b1;
         end
      end
      if (fill == gbp_pkg::BYTE_BITS || row_end) begin
         out_byte = pack_acc;
         // pad the unused low bits of a short byte with ones
         if (fill < gbp_pkg::BYTE_BITS)
            out_byte = out_byte | 8'((1 << (gbp_pkg::BYTE_BITS - fill)) - 1);
         pending_bytes.push_back('{out_byte, gbp_pkg::ST_OK, last_row});
         pack_acc  = '0;
         pack_fill = '0;
      end else begin
         pack_fill = 3'(fill);
      end
   endfunction

   function automatic logic [7:0] pick_legal_pixel();
      int thr;
      int lo;
      int hi;
      int top;
      top = int'(shadow_cfg.max_value);
      thr = (top + 1) / 2;
      if ($urandom_range(1, 0) == 0) return 8'($urandom_range(top, 0));
      // hug the threshold
      lo = (thr > 0) ? thr - 1 : 0;
      hi = (thr + 1 > top) ? top : thr + 1;
      return 8'($urandom_range(hi, lo));
   endfunction

   function automatic logic [15:0] pick_max_word();
      int r;
      r = $urandom_range(9, 0);
      if (r < 5) return {8'($urandom), 8'd255};
      if (r < 8) return {8'($urandom), 8'($urandom_range(254, 1))};
      if (r == 8) return {8'($urandom), 8'd0};
      return {8'($urandom), 8'd1};
   endfunction

   task automatic send_pixel(input logic [7:0] px, input logic eoi);
      @(negedge clock);
      while ($urandom_range(99, 0) < send_gap_pct) begin
         req_ch.valid        <= 1'b0;
         req_ch.pixel        <= 8'($urandom);
         req_ch.end_of_input <= 1'($urandom);
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.pixel        <= px;
      req_ch.end_of_input <= eoi;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (image_done) dropped_sent++;
      else pixels_sent++;
      threshold_and_pack(px, eoi);
   endtask

   task automatic wait_for_bytes();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_bytes.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      wait_for_bytes();
      // pixels that produce no byte may still be in the pipe
      repeat (4) @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      case (idx)
         gbp_pkg::CSR_IMAGE_WIDTH:  shadow_cfg.image_width  = value;
         gbp_pkg::CSR_IMAGE_HEIGHT: shadow_cfg.image_height = value;
         gbp_pkg::CSR_MAX_VALUE:    shadow_cfg.max_value    = value[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic test_directed_patterns();
      logic [7:0] row_px[$];
      write_reg(gbp_pkg::CSR_IMAGE_HEIGHT, 16'hFFFF);
      write_reg(gbp_pkg::CSR_IMAGE_WIDTH, 16'h0000);   // zero width counts as 65536
      write_reg(gbp_pkg::CSR_MAX_VALUE, 16'h00FF);
      write_reg(gbp_pkg::CSR_IMAGE_WIDTH, 16'd8);
      row_px = {8'd0, 8'd255, 8'd128, 8'd129, 8'd127, 8'd1, 8'd254, 8'd200};
      foreach (row_px[i]) send_pixel(row_px[i], 1'b0);
      // full byte, then a three bit tail padded at row end
      write_reg(gbp_pkg::CSR_IMAGE_WIDTH, 16'd11);
      row_px = {8'd255, 8'd0, 8'd64, 8'd192, 8'd128, 8'd129, 8'd3, 8'd252,
                8'd0, 8'd255, 8'd128};
      foreach (row_px[i]) send_pixel(row_px[i], 1'b0);
      // max zero: only black pixels are legal
      write_reg(gbp_pkg::CSR_MAX_VALUE, 16'h0000);
      write_reg(gbp_pkg::CSR_IMAGE_WIDTH, 16'd4);
      row_px = {8'd0, 8'd0, 8'd0, 8'd0};
      foreach (row_px[i]) send_pixel(row_px[i], 1'b0);
      // upper data byte must not reach max_value
      write_reg(gbp_pkg::CSR_MAX_VALUE, 16'h5A01);
      write_reg(gbp_pkg::CSR_IMAGE_WIDTH, 16'd2);
      row_px = {8'd1, 8'd0};
      foreach (row_px[i]) send_pixel(row_px[i], 1'b0);
      write_reg(gbp_pkg::CSR_MAX_VALUE, 16'hA5FE);
      write_reg(gbp_pkg::CSR_IMAGE_WIDTH, 16'd1);
      row_px = {8'd127, 8'd128};
      foreach (row_px[i]) send_pixel(row_px[i], 1'b0);
      write_reg(gbp_pkg::CSR_IMAGE_HEIGHT, 16'h0000);
      wait_for_bytes();
   endtask

   // rows of random length, settings changed between bursts, often mid-row
   task automatic test_random_rows(input int item_goal);
      int start;
      int w;
      int n;
      int cap;
      start = pixels_sent;
      while (pixels_sent - start < item_goal) begin
         case ($urandom_range(19, 0))
            0:             w = $urandom_range(600, 201);
            1, 2, 3, 4, 5: w = $urandom_range(200, 25);
            default:       w = $urandom_range(24, 1);
         endcase
         if (col_cnt != 0 && w <= int'(col_cnt)) w = w + int'(col_cnt);
         write_reg(gbp_pkg::CSR_IMAGE_WIDTH, 16'(w));
         if ($urandom_range(1, 0) == 0) write_reg(gbp_pkg::CSR_MAX_VALUE, pick_max_word());
         if ($urandom_range(9, 0) == 0)
            write_reg(gbp_pkg::CSR_IMAGE_HEIGHT,
                      ($urandom_range(3, 0) == 0) ? 16'h0000 :
                      16'($urandom_range(65535, 4096)));
         cap = (3 * w > 96) ? 96 : 3 * w;
         n = $urandom_range(cap, 1);
         repeat (n) begin
            send_pixel(pick_legal_pixel(), 1'b0);
            if ($urandom_range(49, 0) == 0) wait_for_bytes();
         end
      end
   endtask

   task automatic test_image_close();
      close_kind = image_close_type'($urandom_range(2, 0));
      write_reg(gbp_pkg::CSR_IMAGE_WIDTH, 16'hFFFF);
      write_reg(gbp_pkg::CSR_IMAGE_HEIGHT, row_cnt + 16'd1);
      write_reg(gbp_pkg::CSR_MAX_VALUE, {8'h00, (close_kind == CLOSE_ABOVE_MAX) ?
                                               8'($urandom_range(254, 0)) :
                                               8'($urandom_range(255, 1))});
      repeat ($urandom_range(40, 5)) send_pixel(pick_legal_pixel(), 1'b0);
      case (close_kind)
         CLOSE_COMPLETE: begin
            // shrink the row so it ends soon; this also closes the image
            write_reg(gbp_pkg::CSR_IMAGE_WIDTH, col_cnt + 16'($urandom_range(12, 1)));
            while (!image_done) send_pixel(pick_legal_pixel(), 1'b0);
         end
         CLOSE_ABOVE_MAX:
            send_pixel(8'($urandom_range(255, int'(shadow_cfg.max_value) + 1)), 1'b0);
         default:
            send_pixel(8'($urandom), 1'b1);
      endcase
      wait_for_bytes();
      // everything from here on must be dropped
      repeat (16) send_pixel(8'($urandom), 1'($urandom));
   endtask

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
   end

   always @(posedge clock) begin : check_bytes
      bilevel_byte_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         bytes_checked++;
         if (pending_bytes.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: byte with nothing expected: byte %h status %0d last %0d",
                        $time, rsp_ch.packed_byte, rsp_ch.status, rsp_ch.last);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_ch.packed_byte !== want.packed_byte ||
                rsp_ch.status !== want.status || rsp_ch.last !== want.last) begin
               fail_count++;
               if (fail_count <= 10)
                  $display({"%0t: mismatch exp byte %h status %0d last %0d, ",
                            "got byte %h status %0d last %0d"},
                           $time, want.packed_byte, want.status, want.last,
                           rsp_ch.packed_byte, rsp_ch.status, rsp_ch.last);
            end
         end
      end
   end

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.pixel        = '0;
      req_ch.end_of_input = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = gbp_pkg::CSR_IMAGE_WIDTH;
      csr_ch.data         = '0;
      rsp_ch.ready        = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_gap_pct = 8;
      stall_pct    = 80;
      test_directed_patterns();
      test_random_rows(390);
      send_gap_pct = 80;
      stall_pct    = 8;
      test_random_rows(390);
      send_gap_pct = 0;
      stall_pct    = 0;
      test_random_rows(390);
      test_image_close();

      wait_for_bytes();
      repeat (8) @(negedge clock);
      fail_count = fail_count + pending_bytes.size();

      $display("Covered %0d pixels and %0d packed bytes, %0d items dropped after close",
               pixels_sent, bytes_checked, dropped_sent);
      $display("Widths 0 to 65535, max values 0 to 255, image closed by %s",
               close_kind.name());
      if (fail_count == 0) begin
         $display("gray_to_bilevel_packer verification clean");
      end else begin
         $display("gray_to_bilevel_packer verification failed");
      end
      $finish;
   end

endmodule
